// ----- design/lfs_pkg.sv -----
// Shared constants, result types and helpers of the line field splitter.
package lfs_pkg;

   localparam int MAX_LINE      = 4096;
   localparam int MAX_FIELDS    = 256;
   localparam int MAX_FIELD_LEN = 255;

   localparam int LINE_W = $clog2(MAX_LINE);
   localparam int FD_W   = $clog2(MAX_FIELDS + 1);
   localparam int CFL_W  = $clog2(MAX_FIELD_LEN + 1);

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_TAB   = 8'd9;
   localparam logic [7:0] CHAR_NL    = 8'd10;
   localparam logic [7:0] CHAR_NUL   = 8'd0;
   localparam logic [7:0] WS_SEP     = 8'd32;

   typedef enum logic [1:0] {
      KIND_BYTE       = 2'd0,
      KIND_FIELD_END  = 2'd1,
      KIND_RECORD_END = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [7:0]  field_index;
      logic [7:0]  field_length;
      logic [8:0]  field_count;
      logic [31:0] record_number;
      logic        last;
   } result_type;

   // Results produced by one accepted item, in delivery order.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   function automatic logic [7:0] sat_len(input logic [CFL_W-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return (w > 32'd255) ? 8'hFF : w[7:0];
   endfunction

endpackage

// ----- design/lfs_core.sv -----
// Tokenizer state and per-item result computation of the line field splitter.
module lfs_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [7:0]          csr_wr_data,
   input  logic                accept,
   input  logic [7:0]          text_byte,
   input  logic                end_of_file,
   output lfs_pkg::push_type   push
);

   logic [7:0]                 sep_ff;
   logic [lfs_pkg::LINE_W-1:0] line_length_ff, line_length_in;
   logic [lfs_pkg::FD_W-1:0]   fields_done_ff, fields_done_in;
   logic [lfs_pkg::CFL_W-1:0]  cfl_ff, cfl_in;
   logic                       inside_ff, inside_in;
   logic                       line_cut_ff, line_cut_in;
   logic [31:0]                records_ff, records_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff         <= lfs_pkg::WS_SEP;
         line_length_ff <= '0;
         fields_done_ff <= '0;
         cfl_ff         <= '0;
         inside_ff      <= 1'b0;
         line_cut_ff    <= 1'b0;
         records_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            sep_ff <= csr_wr_data;
         end
         if (accept) begin
            line_length_ff <= line_length_in;
            fields_done_ff <= fields_done_in;
            cfl_ff         <= cfl_in;
            inside_ff      <= inside_in;
            line_cut_ff    <= line_cut_in;
            records_ff     <= records_in;
         end
      end
   end

   always_comb begin
      logic                     ws;
      logic                     fd_open;
      logic                     cfl_room;
      logic                     line_end;
      logic                     do_close;
      logic                     close_op;
      logic                     add_op;
      logic [lfs_pkg::FD_W-1:0] fd_after;
      lfs_pkg::result_type      fe_res;
      lfs_pkg::result_type      by_res;
      lfs_pkg::result_type      rec_res;

      ws       = (sep_ff == lfs_pkg::WS_SEP);
      fd_open  = (fields_done_ff < lfs_pkg::FD_W'(lfs_pkg::MAX_FIELDS));
      cfl_room = (cfl_ff < lfs_pkg::CFL_W'(lfs_pkg::MAX_FIELD_LEN));
      close_op = 1'b0;
      add_op   = 1'b0;
      do_close = 1'b0;
      fd_after = fields_done_ff;

      fe_res              = '0;
      fe_res.kind         = lfs_pkg::KIND_FIELD_END;
      fe_res.field_index  = 8'(fields_done_ff);
      fe_res.field_length = lfs_pkg::sat_len(cfl_ff);

      by_res              = '0;
      by_res.kind         = lfs_pkg::KIND_BYTE;
      by_res.data_byte    = text_byte;
      by_res.field_index  = 8'(fields_done_ff);
      by_res.last         = 1'b1;

      rec_res             = '0;

      line_length_in = line_length_ff;
      fields_done_in = fields_done_ff;
      cfl_in         = cfl_ff;
      inside_in      = inside_ff;
      line_cut_in    = line_cut_ff;
      records_in     = records_ff;

      push = '0;

      if (end_of_file) begin
         line_end = (line_length_ff != '0);
      end else begin
         line_end = (text_byte == lfs_pkg::CHAR_NL) ||
                    (line_length_ff >= lfs_pkg::LINE_W'(lfs_pkg::MAX_LINE - 1));
      end

      if (line_end) begin
         // Whitespace mode closes the last field only if one is open.
         do_close   = !line_cut_ff && (!ws || inside_ff);
         fd_after   = fields_done_ff + lfs_pkg::FD_W'(do_close && fd_open);
         records_in = records_ff + 32'd1;

         rec_res.kind          = lfs_pkg::KIND_RECORD_END;
         rec_res.field_count   = 9'(fd_after);
         rec_res.record_number = records_in;
         rec_res.last          = 1'b1;

         if (do_close && fd_open) begin
            push.count  = 2'd2;
            push.first  = fe_res;
            push.second = rec_res;
         end else begin
            push.count  = 2'd1;
            push.first  = rec_res;
         end

         line_length_in = '0;
         fields_done_in = '0;
         cfl_in         = '0;
         inside_in      = 1'b0;
         line_cut_in    = 1'b0;
      end else if (!end_of_file) begin
         line_length_in = line_length_ff + lfs_pkg::LINE_W'(1);
         if (!line_cut_ff) begin
            if (text_byte == lfs_pkg::CHAR_NUL) begin
               close_op    = !ws || inside_ff;
               line_cut_in = 1'b1;
            end else if (ws) begin
               if ((text_byte == lfs_pkg::CHAR_SPACE) || (text_byte == lfs_pkg::CHAR_TAB)) begin
                  close_op = inside_ff;
               end else begin
                  inside_in = 1'b1;
                  add_op    = 1'b1;
               end
            end else if (text_byte == sep_ff) begin
               close_op = 1'b1;
            end else begin
               add_op = 1'b1;
            end
         end
      end

      if (close_op) begin
         if (fd_open) begin
            push.count       = 2'd1;
            push.first       = fe_res;
            push.first.last  = 1'b1;
            fields_done_in   = fields_done_ff + lfs_pkg::FD_W'(1);
         end
         cfl_in    = '0;
         inside_in = 1'b0;
      end

      if (add_op) begin
         if (fd_open && cfl_room) begin
            push.count = 2'd1;
            push.first = by_res;
         end
         if (cfl_room) begin
            cfl_in = cfl_ff + lfs_pkg::CFL_W'(1);
         end
      end

      if (!accept) begin
         push.count = 2'd0;
      end
   end

endmodule

// ----- design/lfs_out_queue.sv -----
// Small result queue that takes up to two results a cycle and delivers one while out_ready is high.
module lfs_out_queue (
   input  logic                clock,
   input  logic                reset,
   input  lfs_pkg::push_type   push,
   output logic                has_room,
   output logic                out_valid,
   input  logic                out_ready,
   output lfs_pkg::result_type out_item
);

   lfs_pkg::result_type         entry_ff [lfs_pkg::QDEPTH];
   logic [lfs_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [lfs_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [lfs_pkg::QPTR_W:0]    count_ff, count_in;
   logic                        pop;
   logic [lfs_pkg::QPTR_W-1:0]  wr_next;

   assign out_valid = (count_ff != '0);
   assign out_item  = entry_ff[rd_ptr_ff];
   assign has_room  = (count_ff <= (lfs_pkg::QPTR_W + 1)'(lfs_pkg::QDEPTH - 2));
   assign pop       = out_valid && out_ready;
   assign wr_next   = wr_ptr_ff + lfs_pkg::QPTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + lfs_pkg::QPTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + lfs_pkg::QPTR_W'(pop);
      count_in  = count_ff + (lfs_pkg::QPTR_W + 1)'(push.count)
                  - (lfs_pkg::QPTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

endmodule

// ----- design/line_field_splitter_top.sv -----
// Top level of the line field splitter: stream ports, tokenizer and result queue.
//
// The block splits a byte stream into records and fields, one input item per clock cycle
// while req_tready is high. Each item is worked on by the tokenizer in the cycle it is
// accepted, and its results sit in a four-entry queue from the next cycle on. An item
// gives at most one result except at a line end that closes a field, which gives a field
// end and then a record end; the output port moves one result a cycle while rsp_tready is
// high, so such an item takes two output transfers. req_tready drops while the queue has
// fewer than two free entries. The separator register is taken in at any write and is
// used from the next item on; write it only while no results are pending.
module line_field_splitter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // text_byte
   input  logic        req_tlast,   // end_of_file
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // data_byte[7:0], field_index[15:8], field_length[23:16], field_count[32:24],
   // record_number[64:33], zero fill[71:65]
   output logic [71:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // kind
   output logic        rsp_tlast    // last
);

   logic                accept;
   lfs_pkg::push_type   push;
   lfs_pkg::result_type head;

   assign accept = req_tvalid && req_tready;

   lfs_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .text_byte   (req_tdata),
      .end_of_file (req_tlast),
      .push        (push)
   );

   lfs_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .has_room  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (head)
   );

   assign rsp_tdata = {7'd0, head.record_number, head.field_count, head.field_length,
                       head.field_index, head.data_byte};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule

// ----- design/lfs_checker.sv -----
// Port-level checks of the line field splitter, bound to its top level.
module lfs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // A stalled result must hold still until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Nothing is pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result shown after reset");

   // A record end is always the final result of its item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == lfs_pkg::KIND_RECORD_END) |-> rsp_tlast)
      else $error("record end without last");

   // A field byte never shares its item with another result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == lfs_pkg::KIND_BYTE) |-> rsp_tlast)
      else $error("field byte without last");

   // A result without last is a field end that a record end follows at once.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && (rsp_tuser == lfs_pkg::KIND_RECORD_END))
      else $error("field end not followed by record end");

endmodule

bind line_field_splitter_top lfs_checker u_lfs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
